>>> hw/rtl/stbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-table binary search: shared types and constants
// Item formats for the request and response channels, table geometry and
// command codes.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TableDepth = 16;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CountW     = IdxW + 1;   // holds 0..2*TableDepth-1
    localparam int DataW      = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [CountW-1:0] COUNT_RESET = CountW'(TableDepth);

    typedef struct packed {
        logic                    cmd;
        logic [IdxW-1:0]         entry_index;
        logic signed [DataW-1:0] entry_value;
        logic signed [DataW-1:0] search_key;
    } stbs_req_t;

    typedef struct packed {
        logic            is_write_ack;
        logic            found;
        logic [IdxW-1:0] position;
    } stbs_rsp_t;

endpackage

>>> hw/rtl/sorted_table_binary_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-table binary search unit
// Holds a 16-entry table of signed words in a synchronous RAM and runs a
// binary search over the first entry_count entries for each search item.
// ----------------------------------------------------------------------------
// One item is handled at a time. A write item stores its value the cycle it
// is accepted and its acknowledge is presented on the next cycle. Each
// probe of a search item is a RAM read, then a compare; a hit is registered
// by the compare of its matching probe. A miss needs one more probe state
// to see the range empty; for an empty range that is the first one. The
// registered read of the table RAM sets the per-probe cost. A finished
// response waits in the output register; the next item is taken as soon as
// that register is empty or being drained. entry_count resets to 16 and
// values above 16 act as 16.
module sorted_table_binary_search_unit
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               req_valid,
    output logic               req_stall,
    input  stbs_pkg::stbs_req_t req,

    output logic               rsp_valid,
    input  logic               rsp_stall,
    output stbs_pkg::stbs_rsp_t rsp,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [stbs_pkg::CountW-1:0] cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;

    localparam int BoundW = stbs_pkg::CountW + 1;

    logic [1:0]                          state_reg, state_next;
    logic [stbs_pkg::CountW-1:0]         count_reg;
    logic [stbs_pkg::CountW-1:0]         left_reg, left_next;
    logic signed [BoundW-1:0]            right_reg, right_next;
    logic signed [stbs_pkg::DataW-1:0]   key_reg;
    logic [stbs_pkg::IdxW-1:0]           mid_reg;
    logic                                rsp_valid_reg, rsp_valid_next;
    stbs_pkg::stbs_rsp_t                 rsp_reg, rsp_next;

    logic signed [stbs_pkg::DataW-1:0]   table_mem [stbs_pkg::TableDepth];
    logic signed [stbs_pkg::DataW-1:0]   rdata_reg;

    logic                                req_accept;
    logic [stbs_pkg::CountW-1:0]         count_sat;
    logic signed [BoundW-1:0]            left_s;
    logic signed [BoundW-1:0]            span;
    logic [BoundW-1:0]                   mid_full;
    logic [stbs_pkg::IdxW-1:0]           mid;

    assign req_stall  = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign count_sat = (count_reg > stbs_pkg::COUNT_RESET) ? stbs_pkg::COUNT_RESET
                                                          : count_reg;

    // midpoint = left + (right - left) / 2, only used while left <= right
    assign left_s   = $signed({1'b0, left_reg});
    assign span     = right_reg - left_s;
    assign mid_full = $unsigned(left_s + (span >>> 1));
    assign mid      = mid_full[stbs_pkg::IdxW-1:0];

    // table RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req_accept && req.cmd == stbs_pkg::CMD_WRITE)
        begin
            table_mem[req.entry_index] <= req.entry_value;
        end
        rdata_reg <= table_mem[mid];
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            key_reg <= req.search_key;
        end
        if (state_reg == S_PROBE)
        begin
            mid_reg <= mid;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    if (req.cmd == stbs_pkg::CMD_WRITE)
                    begin
                        rsp_valid_next        = 1'b1;
                        rsp_next.is_write_ack = 1'b1;
                        rsp_next.found        = 1'b0;
                        rsp_next.position     = req.entry_index;
                    end
                    else
                    begin
                        left_next  = '0;
                        right_next = $signed({1'b0, count_sat}) - BoundW'(1);
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (left_s > right_reg)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.is_write_ack = 1'b0;
                    rsp_next.found        = 1'b0;
                    rsp_next.position     = '0;
                    state_next            = S_IDLE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rdata_reg < key_reg)
                begin
                    left_next  = {1'b0, mid_reg} + stbs_pkg::CountW'(1);
                    state_next = S_PROBE;
                end
                else if (rdata_reg > key_reg)
                begin
                    right_next = $signed({2'b00, mid_reg}) - BoundW'(1);
                    state_next = S_PROBE;
                end
                else
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.is_write_ack = 1'b0;
                    rsp_next.found        = 1'b1;
                    rsp_next.position     = mid_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= stbs_pkg::COUNT_RESET;
            rsp_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

>>> dv/tb_sorted_table_binary_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted-table binary search unit
// Loads the table with sorted, duplicate-heavy and unsorted contents, runs
// searches for present, absent and extreme keys across several entry counts,
// and checks every write acknowledge and search result against an in-bench
// binary search over a mirror of the table. The request channel idles and
// the response channel stalls at random.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_unit;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int ITEM_TARGET    = 750;
    localparam int QUIET_AFTER    = 600;

    localparam int DW     = stbs_pkg::DataW;
    localparam int IW     = stbs_pkg::IdxW;
    localparam int CW     = stbs_pkg::CountW;
    localparam int DEPTH  = stbs_pkg::TableDepth;

    localparam logic signed [DW-1:0] MIN_WORD = 32'sh8000_0000;
    localparam logic signed [DW-1:0] MAX_WORD = 32'sh7fff_ffff;

    // Mirror of the table plus the entry count, and the queue of results
    // still owed by the block.
    class bsearch_scoreboard;
        logic signed [DW-1:0]  entries [DEPTH];
        logic [CW-1:0]         count;
        stbs_pkg::stbs_rsp_t   pending_results [$];
        int                    errors;
        int                    n_writes;
        int                    n_hits;
        int                    n_misses;

        function new();
            count    = stbs_pkg::COUNT_RESET;
            errors   = 0;
            n_writes = 0;
            n_hits   = 0;
            n_misses = 0;
            foreach (entries[i]) entries[i] = '0;
        endfunction

        function void set_count(logic [CW-1:0] v);
            count = v;
        endfunction

        function stbs_pkg::stbs_rsp_t predict_search(logic signed [DW-1:0] key);
            int                  lo;
            int                  hi;
            int                  mid;
            int                  n;
            stbs_pkg::stbs_rsp_t r;
            r  = '0;
            n  = (count > DEPTH) ? DEPTH : int'(count);
            lo = 0;
            hi = n - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (entries[mid] < key)
                begin
                    lo = mid + 1;
                end
                else if (entries[mid] > key)
                begin
                    hi = mid - 1;
                end
                else
                begin
                    r.found    = 1'b1;
                    r.position = mid[IW-1:0];
                    break;
                end
            end
            return r;
        endfunction

        function void note_item(stbs_pkg::stbs_req_t item);
            stbs_pkg::stbs_rsp_t r;
            if (item.cmd == stbs_pkg::CMD_WRITE)
            begin
                entries[item.entry_index] = item.entry_value;
                r              = '0;
                r.is_write_ack = 1'b1;
                r.position     = item.entry_index;
                n_writes++;
            end
            else
            begin
                r = predict_search(item.search_key);
                if (r.found) n_hits++;
                else n_misses++;
            end
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at time %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(stbs_pkg::stbs_rsp_t got);
            stbs_pkg::stbs_rsp_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %p with nothing outstanding", got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.is_write_ack !== want.is_write_ack)
                    report_mismatch($sformatf("is_write_ack got %b want %b",
                                              got.is_write_ack, want.is_write_ack));
                if (got.found !== want.found)
                    report_mismatch($sformatf("found got %b want %b",
                                              got.found, want.found));
                if (got.position !== want.position)
                    report_mismatch($sformatf("position got %0d want %0d",
                                              got.position, want.position));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    stbs_pkg::stbs_req_t   req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    stbs_pkg::stbs_rsp_t   rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CW-1:0]         cfg_data;

    bsearch_scoreboard     sb;
    int                    items_sent   = 0;
    int                    count_writes = 0;
    int                    stall_cycles = 0;
    bit                    no_idle      = 1'b0;
    bit                    long_hold    = 1'b0;

    sorted_table_binary_search_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // Watchdog: cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_sorted_table_binary_search_unit NOT OK");
                $finish;
            end
        end
    end

    // Receiver back-pressure: random short bursts, or one long hold on request.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 25)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic stbs_pkg::stbs_req_t make_write(logic [IW-1:0] idx,
                                                       logic signed [DW-1:0] val);
        stbs_pkg::stbs_req_t r;
        r.cmd         = stbs_pkg::CMD_WRITE;
        r.entry_index = idx;
        r.entry_value = val;
        r.search_key  = $urandom;
        return r;
    endfunction

    function automatic stbs_pkg::stbs_req_t make_search(logic signed [DW-1:0] key);
        stbs_pkg::stbs_req_t r;
        r.cmd         = stbs_pkg::CMD_SEARCH;
        r.entry_index = IW'($urandom_range(0, DEPTH - 1));
        r.entry_value = $urandom;
        r.search_key  = key;
        return r;
    endfunction

    // Mostly keys that are in the active range, plus neighbors and strays.
    function automatic logic signed [DW-1:0] pick_key();
        int                   n;
        int                   sel;
        logic signed [DW-1:0] e;
        n = (sb.count > DEPTH) ? DEPTH : int'(sb.count);
        if (n == 0) n = DEPTH;
        e   = sb.entries[$urandom_range(0, n - 1)];
        sel = $urandom_range(0, 9);
        case (sel)
            6:       return e + 1;
            7:       return e - 1;
            8:       return $urandom;
            9:       return $urandom_range(0, 1) ? MIN_WORD : MAX_WORD;
            default: return e;
        endcase
    endfunction

    task automatic send_item(input stbs_pkg::stbs_req_t item);
        @(negedge clk);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_item(item);
        items_sent++;
    endtask

    task automatic idle_burst(input int n);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic maybe_idle();
        if (!no_idle && $urandom_range(0, 99) < 25)
            idle_burst($urandom_range(1, 3));
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(input logic [CW-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_count(v);
        count_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Modes: 0/1 wide random, 2 narrow range (duplicates), 3 with extremes,
    // 4 left unsorted.
    task automatic load_table(input int mode);
        int vals [$];
        for (int i = 0; i < DEPTH; i++)
        begin
            if (mode == 2) vals.push_back(int'($urandom_range(0, 20)) - 10);
            else vals.push_back(int'($urandom));
        end
        if (mode != 4) vals.sort();
        if (mode == 3)
        begin
            vals[0]         = MIN_WORD;
            vals[DEPTH - 1] = MAX_WORD;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            send_item(make_write(i[IW-1:0], vals[i]));
            maybe_idle();
        end
    endtask

    initial
    begin
        int n_phase_items;
        int sel;
        int p;
        logic [CW-1:0] cnt;

        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: fixed sorted table with both extremes at the ends.
        write_count(CW'(DEPTH));
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0) send_item(make_write(IW'(i), MIN_WORD));
            else if (i == DEPTH - 1) send_item(make_write(IW'(i), MAX_WORD));
            else send_item(make_write(IW'(i), (i - 7) * 1000));
        end
        send_item(make_search(MIN_WORD));
        send_item(make_search(MAX_WORD));
        send_item(make_search(3000));
        send_item(make_search(2500));
        send_item(make_search(-1));
        write_count('0);                         // empty search range
        send_item(make_search(0));
        write_count(5'd31);                      // saturates to the depth
        send_item(make_search(MAX_WORD));
        write_count(5'd1);
        send_item(make_search(MIN_WORD));

        // Random phases: new count, optional reload, then a burst of items.
        p = 0;
        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       cnt = '0;
                1:       cnt = 5'd1;
                2:       cnt = CW'($urandom_range(17, 31));
                3:       cnt = CW'(DEPTH);
                default: cnt = CW'($urandom_range(2, DEPTH));
            endcase
            write_count(cnt);
            if (p == 0 || $urandom_range(0, 99) < 40)
                load_table($urandom_range(0, 4));
            if (p == 2) long_hold = 1'b1;
            n_phase_items = $urandom_range(20, 40);
            for (int k = 0; k < n_phase_items; k++)
            begin
                if (p == 4 && k == n_phase_items / 2)
                    drain_results();
                if ($urandom_range(0, 99) < 8)
                    send_item(make_write(IW'($urandom_range(0, DEPTH - 1)), $urandom));
                else
                    send_item(make_search(pick_key()));
                if (items_sent >= QUIET_AFTER) no_idle = 1'b1;
                maybe_idle();
            end
            p++;
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("run: %0d items, %0d writes, %0d searches (%0d hits, %0d misses)",
                 items_sent, sb.n_writes, sb.n_hits + sb.n_misses, sb.n_hits,
                 sb.n_misses);
        $display("run: %0d entry-count settings over %0d phases, %0d mismatches",
                 count_writes, p, sb.errors);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb_sorted_table_binary_search_unit OK");
        else
            $display("tb_sorted_table_binary_search_unit NOT OK");
        $finish;
    end

endmodule
